// ----- sv/kgc_pkg.sv -----
package kgc_pkg;

   // Field widths fixed by the poll and event formats
   localparam int KEYS_FIELD_BITS = 2;
   localparam int NOW_FIELD_BITS  = 32;
   localparam int CSR_INDEX_BITS  = 4;
   localparam int CSR_DATA_BITS   = 16;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_PRESS      = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REPEAT_INTERVAL = 4'd1;

   // Register reset values
   localparam logic [CSR_DATA_BITS-1:0] LONG_PRESS_RESET      = 16'd500;
   localparam logic [CSR_DATA_BITS-1:0] REPEAT_INTERVAL_RESET = 16'd120;

   typedef enum logic [2:0] {
      EV_PRESS   = 3'd0,
      EV_RELEASE = 3'd1,
      EV_SHORT   = 3'd2,
      EV_LONG    = 3'd3,
      EV_REPEAT  = 3'd4
   } kgc_event_type;

   typedef struct packed {
      logic [KEYS_FIELD_BITS-1:0] keys_down;
      logic [NOW_FIELD_BITS-1:0]  now_ms;
   } kgc_req_type;

   typedef struct packed {
      logic       key_index;
      logic [2:0] event_kind;
      logic       last_of_poll;
   } kgc_rsp_type;

   // Events one key lane found for the current poll
   typedef struct packed {
      logic          first_valid;
      kgc_event_type first_kind;
      logic          short_valid;
   } kgc_lane_ev_type;

endpackage

// ----- sv/kgc_lane.sv -----
module kgc_lane
   import kgc_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic                     down,
   input  logic [TIME_BITS-1:0]     now,
   input  logic [CSR_DATA_BITS-1:0] long_press_ms,
   input  logic [CSR_DATA_BITS-1:0] repeat_interval_ms,
   output kgc_lane_ev_type          ev
);

   logic                 held_ff, held_in;
   logic                 long_done_ff, long_done_in;
   logic [TIME_BITS-1:0] press_time_ff, press_time_in;
   logic [TIME_BITS-1:0] repeat_time_ff, repeat_time_in;

   logic [TIME_BITS-1:0] held_for;
   logic [TIME_BITS-1:0] since_rep;
   logic                 held_long;
   logic                 rep_due;
   logic                 is_press, is_release, is_long, is_repeat;

   // Elapsed times wrap with the time width
   assign held_for  = now - press_time_ff;
   assign since_rep = now - repeat_time_ff;
   assign held_long = held_for >= TIME_BITS'(long_press_ms);
   assign rep_due   = since_rep > TIME_BITS'(repeat_interval_ms);

   // Classify in priority order
   assign is_press   = down && !held_ff;
   assign is_release = !down && held_ff;
   assign is_long    = down && held_ff && !long_done_ff && held_long;
   assign is_repeat  = down && held_ff && long_done_ff && rep_due;

   always_comb begin
      ev.first_valid = is_press || is_release || is_long || is_repeat;
      ev.first_kind  = EV_PRESS;
      if (is_release) begin
         ev.first_kind = EV_RELEASE;
      end else if (is_long) begin
         ev.first_kind = EV_LONG;
      end else if (is_repeat) begin
         ev.first_kind = EV_REPEAT;
      end
      ev.short_valid = is_release && !long_done_ff && !held_long;
   end

   // Next key state, taken only when the poll transfers
   always_comb begin
      held_in        = held_ff;
      long_done_in   = long_done_ff;
      press_time_in  = press_time_ff;
      repeat_time_in = repeat_time_ff;
      if (is_press) begin
         held_in       = 1'b1;
         press_time_in = now;
         long_done_in  = 1'b0;
      end else if (is_release) begin
         held_in = 1'b0;
      end else if (is_long) begin
         long_done_in   = 1'b1;
         repeat_time_in = now;
      end else if (is_repeat) begin
         repeat_time_in = now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff        <= 1'b0;
         long_done_ff   <= 1'b0;
         press_time_ff  <= '0;
         repeat_time_ff <= '0;
      end else if (accept) begin
         held_ff        <= held_in;
         long_done_ff   <= long_done_in;
         press_time_ff  <= press_time_in;
         repeat_time_ff <= repeat_time_in;
      end
   end

endmodule

// ----- sv/kgc_merge.sv -----
module kgc_merge
   import kgc_pkg::*;
#(
   parameter int NUM_KEYS = 2
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  kgc_lane_ev_type lane_ev [NUM_KEYS],
   output logic            busy,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output kgc_rsp_type     rsp_data
);

   localparam int SLOTS     = 2 * NUM_KEYS;
   localparam int SLOT_BITS = $clog2(SLOTS);

   logic [SLOTS-1:0] pending_ff, pending_in;
   logic [2:0]       kind_ff [SLOTS];
   logic             rsp_valid_ff, rsp_valid_in;
   kgc_rsp_type      rsp_data_ff, rsp_data_in;

   logic [SLOTS-1:0]     lowest;
   logic [SLOTS-1:0]     rest;
   logic [SLOT_BITS-1:0] sel;
   logic [SLOT_BITS-1:0] sel_key;
   logic                 move;
   logic [SLOTS-1:0]     load_mask;

   // Pick the lowest pending slot, which is the next event in key order
   assign lowest = pending_ff & (~pending_ff + 1'b1);
   assign rest   = pending_ff & ~lowest;

   always_comb begin
      sel = '0;
      for (int j = SLOTS - 1; j >= 0; j--) begin
         if (pending_ff[j]) begin
            sel = SLOT_BITS'(j);
         end
      end
   end

   assign sel_key = sel >> 1;
   assign move    = (|pending_ff) && (!rsp_valid_ff || !rsp_stall);

   // Hold off a new poll until the last buffered event moves out
   assign busy = move ? (|rest) : (|pending_ff);

   always_comb begin
      for (int k = 0; k < NUM_KEYS; k++) begin
         load_mask[2*k]     = lane_ev[k].first_valid;
         load_mask[2*k + 1] = lane_ev[k].short_valid;
      end
   end

   always_comb begin
      pending_in = pending_ff;
      if (load) begin
         pending_in = load_mask;
      end else if (move) begin
         pending_in = rest;
      end
   end

   // Output register: advance on a free or transferring slot
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (move) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.key_index    = sel_key[0];
         rsp_data_in.event_kind   = kind_ff[sel];
         rsp_data_in.last_of_poll = ~(|rest);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (load) begin
         for (int k = 0; k < NUM_KEYS; k++) begin
            kind_ff[2*k]     <= lane_ev[k].first_kind;
            kind_ff[2*k + 1] <= EV_SHORT;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- sv/key_gesture_classifier.sv -----
// Channel | Direction | Handshake              | Payload
// req     | in        | req_valid / req_stall  | kgc_req_type (keys_down, now_ms)
// rsp     | out       | rsp_valid / rsp_stall  | kgc_rsp_type (key_index, event_kind, last)
// csr     | in        | csr_valid / csr_ready  | csr_index, csr_data
//
// All key lanes classify a poll in parallel as it transfers.
// Its events leave one per cycle while rsp_stall is low, through the event
// buffer and then the output register, so a poll with events holds off the
// next poll, which transfers as the last event enters the output register.
// Quiet polls do not hold off the next poll. Reset clears key state and loads the
// register defaults. rsp_stall holds the output register and, once the
// event buffer is left with events, req_stall.
module key_gesture_classifier
   import kgc_pkg::*;
#(
   parameter int NUM_KEYS  = 2,
   parameter int TIME_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  kgc_req_type               req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output kgc_rsp_type               rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   logic [CSR_DATA_BITS-1:0] long_press_ff, long_press_in;
   logic [CSR_DATA_BITS-1:0] repeat_ivl_ff, repeat_ivl_in;
   logic                     busy;
   logic                     accept;
   logic [TIME_BITS-1:0]     now;
   kgc_lane_ev_type          lane_ev [NUM_KEYS];

   // Register writes always complete
   assign csr_ready = 1'b1;

   always_comb begin
      long_press_in = long_press_ff;
      repeat_ivl_in = repeat_ivl_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LONG_PRESS:      long_press_in = csr_data;
            CSR_REPEAT_INTERVAL: repeat_ivl_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff <= LONG_PRESS_RESET;
         repeat_ivl_ff <= REPEAT_INTERVAL_RESET;
      end else begin
         long_press_ff <= long_press_in;
         repeat_ivl_ff <= repeat_ivl_in;
      end
   end

   assign req_stall = busy;
   assign accept    = req_valid && !busy;
   assign now       = req_data.now_ms[TIME_BITS-1:0];

   // One lane per key; keys beyond the poll field read as released
   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
      logic down;
      if (k < KEYS_FIELD_BITS) begin : g_bit
         assign down = req_data.keys_down[k];
      end else begin : g_none
         assign down = 1'b0;
      end

      kgc_lane #(
         .TIME_BITS(TIME_BITS)
      ) u_lane (
         .clock              (clock),
         .reset              (reset),
         .accept             (accept),
         .down               (down),
         .now                (now),
         .long_press_ms      (long_press_ff),
         .repeat_interval_ms (repeat_ivl_ff),
         .ev                 (lane_ev[k])
      );
   end

   kgc_merge #(
      .NUM_KEYS(NUM_KEYS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .lane_ev   (lane_ev),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- sv/kgc_checker.sv -----
module kgc_checker
   import kgc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input kgc_rsp_type rsp_data,
   input logic        csr_valid,
   input logic        csr_ready
);

   // Drop any result after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Advance straight to the next event of an unfinished poll
   a_poll_runs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_of_poll |=> rsp_valid)
      else $error("gap inside the events of one poll");

   // Keep new polls out while a stalled poll still has events to deliver
   a_poll_order: assert property (@(posedge clock) disable iff (reset)
      req_valid && rsp_valid && rsp_stall && !rsp_data.last_of_poll |-> req_stall)
      else $error("poll taken before previous poll finished");

   // Complete every register write at once
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write not taken");

endmodule

bind key_gesture_classifier kgc_checker u_kgc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);
